@@ rtl/ttb_pkg.sv @@
`default_nettype none
package ttb_pkg;

  // Widths of the arithmetic path
  localparam int CoordW = 32;             // Q16.16 input coordinate
  localparam int DiffW  = CoordW + 1;     // exact difference of two coordinates
  localparam int ProdW  = 2 * DiffW;      // exact signed product and product difference
  localparam int MagW   = ProdW - 1;      // magnitude of a product difference
  localparam int NormW  = 30;             // significant bits kept after alignment
  localparam int FracW  = 14;             // Q1.14 fraction bits
  localparam int CompW  = 16;             // output component width

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] tex_u;
    logic signed [CoordW-1:0] tex_v;
  } ttb_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] tangent_x;
    logic signed [CompW-1:0] tangent_y;
    logic signed [CompW-1:0] tangent_z;
    logic signed [CompW-1:0] bitangent_x;
    logic signed [CompW-1:0] bitangent_y;
    logic signed [CompW-1:0] bitangent_z;
    logic                    degenerate;
  } ttb_out_t;

endpackage
`default_nettype wire

@@ rtl/ttb_mul.sv @@
`default_nettype none
module ttb_mul import ttb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic signed [DiffW-1:0] a,
  input  wire logic signed [DiffW-1:0] b,
  output logic signed [ProdW-1:0]      p_r
);

  // Registered signed multiply; result is exact at ProdW bits
  always_ff @(posedge clk) begin
    p_r <= ProdW'(a) * ProdW'(b);
  end

endmodule
`default_nettype wire

@@ rtl/triangle_tangent_basis_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    ttb_in_t  (vertex position and UV, Q16.16)
// out_      output     out_valid / out_ready  ttb_out_t (unit tangent, bitangent, degenerate)
//
// First and second vertex of a triangle only load the hold registers.
// Third vertex: products on the shared 33x33 multiplier, then per vector a load, an align,
// the squares, a square root and three divisions, one per component, up to out_valid.
// Degenerate triangles finish early: on a zero determinant or a zero tangent or bitangent.
// Reset (rst_n low, synchronous) clears the hold registers, vertex slot and the output valid.
// A waiting result stalls only the next third vertex; first and second vertices are still taken.
module triangle_tangent_basis_unit import ttb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ttb_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ttb_out_t      out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_DSET  = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  localparam int SqW  = 2 * NormW + 2;      // sum of three squares
  localparam int CsW  = 64;                 // compare-subtract width
  localparam int NumW = NormW + FracW + 1;  // c * 2^14 + n/2

  // Control
  logic [2:0] state_r;
  logic [4:0] cnt_r;
  logic [1:0] slot_r;
  logic       vsel_r;     // 0: tangent, 1: bitangent
  logic [1:0] ci_r;       // component in division
  logic       out_valid_r;

  // Hold registers for v0 and v1
  logic signed [CoordW-1:0] hp_r [6];
  logic signed [CoordW-1:0] ht_r [4];

  // Edge and UV deltas of the current triangle
  logic signed [DiffW-1:0] e1_r [3];
  logic signed [DiffW-1:0] e2_r [3];
  logic signed [DiffW-1:0] du1_r, dv1_r, du2_r, dv2_r;

  // Product results: det, T x/y/z, B x/y/z
  logic signed [ProdW-1:0] vec_r [7];
  logic signed [ProdW-1:0] acc_r;

  // Normalization datapath
  logic [MagW-1:0]  w_r [3];
  logic [2:0]       sgn_r;
  logic             flip_r;
  logic [SqW-1:0]   sum_r;
  logic [SqW-1:0]   x_r;
  logic [CsW-1:0]   root_r;
  logic [CsW-1:0]   sbit_r;
  logic [NormW:0]   rem_r;
  logic [15:0]      nlo_r;
  logic [15:0]      q_r;
  logic signed [CompW-1:0] tn_r [3];
  logic signed [CompW-1:0] bn_r [3];
  ttb_out_t         out_r;

  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  logic [CsW-1:0] cs_a, cs_b, cs_diff;
  logic           cs_ge;

  logic [MagW-1:0]      w_or;
  logic [NormW-1:0]     c_sel;
  logic [NumW-1:0]      num;
  logic [15:0]          q_fin;
  logic signed [CompW-1:0] q_signed;
  logic [3:0]           jdx;
  logic                 in_acc;

  assign in_ready  = (state_r == S_IDLE) && !((slot_r == 2'd2) && out_valid_r);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ttb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      case (cnt_r[1:0])
        2'd0:    mul_a = DiffW'(w_r[0][MagW-1 -: NormW]);
        2'd1:    mul_a = DiffW'(w_r[1][MagW-1 -: NormW]);
        2'd2:    mul_a = DiffW'(w_r[2][MagW-1 -: NormW]);
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end else begin
      case (cnt_r)
        5'd0:    begin mul_a = du1_r; mul_b = dv2_r;   end
        5'd1:    begin mul_a = du2_r; mul_b = dv1_r;   end
        5'd2:    begin mul_a = dv2_r; mul_b = e1_r[0]; end
        5'd3:    begin mul_a = dv1_r; mul_b = e2_r[0]; end
        5'd4:    begin mul_a = dv2_r; mul_b = e1_r[1]; end
        5'd5:    begin mul_a = dv1_r; mul_b = e2_r[1]; end
        5'd6:    begin mul_a = dv2_r; mul_b = e1_r[2]; end
        5'd7:    begin mul_a = dv1_r; mul_b = e2_r[2]; end
        5'd8:    begin mul_a = du1_r; mul_b = e2_r[0]; end
        5'd9:    begin mul_a = du2_r; mul_b = e1_r[0]; end
        5'd10:   begin mul_a = du1_r; mul_b = e2_r[1]; end
        5'd11:   begin mul_a = du2_r; mul_b = e1_r[1]; end
        5'd12:   begin mul_a = du1_r; mul_b = e2_r[2]; end
        5'd13:   begin mul_a = du2_r; mul_b = e1_r[2]; end
        default: begin mul_a = '0;    mul_b = '0;      end
      endcase
    end
  end

  // Shared compare-subtract: square-root step or division step
  always_comb begin
    if (state_r == S_SQRT) begin
      cs_a = CsW'(x_r);
      cs_b = root_r + sbit_r;
    end else begin
      cs_a = CsW'({rem_r, nlo_r[15]});
      cs_b = CsW'(root_r[NormW:0]);
    end
    cs_ge   = (cs_a >= cs_b);
    cs_diff = cs_a - cs_b;
  end

  always_comb begin
    w_or = w_r[0] | w_r[1] | w_r[2];
    case (ci_r)
      2'd0:    c_sel = w_r[0][MagW-1 -: NormW];
      2'd1:    c_sel = w_r[1][MagW-1 -: NormW];
      2'd2:    c_sel = w_r[2][MagW-1 -: NormW];
      default: c_sel = '0;
    endcase
    // c * 2^14 + floor(n / 2)
    num      = {1'b0, c_sel, {FracW{1'b0}}} + NumW'(root_r[NormW:1]);
    q_fin    = {q_r[14:0], cs_ge};
    case (ci_r)
      2'd0:    q_signed = (sgn_r[0] ^ flip_r) ? -$signed(q_fin) : $signed(q_fin);
      2'd1:    q_signed = (sgn_r[1] ^ flip_r) ? -$signed(q_fin) : $signed(q_fin);
      default: q_signed = (sgn_r[2] ^ flip_r) ? -$signed(q_fin) : $signed(q_fin);
    endcase
    jdx = 4'(cnt_r - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      slot_r      <= '0;
      vsel_r      <= 1'b0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) hp_r[i] <= '0;
      for (int i = 0; i < 4; i++) ht_r[i] <= '0;
    end else begin
      // Drop the output once taken
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (slot_r != 2'd2) begin
              // Hold v0 or v1; an unused slot code counts as the first vertex
              if (slot_r == 2'd1) begin
                hp_r[3] <= in_data.pos_x;
                hp_r[4] <= in_data.pos_y;
                hp_r[5] <= in_data.pos_z;
                ht_r[2] <= in_data.tex_u;
                ht_r[3] <= in_data.tex_v;
                slot_r  <= 2'd2;
              end else begin
                hp_r[0] <= in_data.pos_x;
                hp_r[1] <= in_data.pos_y;
                hp_r[2] <= in_data.pos_z;
                ht_r[0] <= in_data.tex_u;
                ht_r[1] <= in_data.tex_v;
                slot_r  <= 2'd1;
              end
            end else begin
              // Third vertex: latch exact deltas and start the products
              e1_r[0] <= DiffW'(hp_r[3]) - DiffW'(hp_r[0]);
              e1_r[1] <= DiffW'(hp_r[4]) - DiffW'(hp_r[1]);
              e1_r[2] <= DiffW'(hp_r[5]) - DiffW'(hp_r[2]);
              e2_r[0] <= DiffW'(in_data.pos_x) - DiffW'(hp_r[3]);
              e2_r[1] <= DiffW'(in_data.pos_y) - DiffW'(hp_r[4]);
              e2_r[2] <= DiffW'(in_data.pos_z) - DiffW'(hp_r[5]);
              du1_r   <= DiffW'(ht_r[2]) - DiffW'(ht_r[0]);
              dv1_r   <= DiffW'(ht_r[3]) - DiffW'(ht_r[1]);
              du2_r   <= DiffW'(in_data.tex_u) - DiffW'(ht_r[2]);
              dv2_r   <= DiffW'(in_data.tex_v) - DiffW'(ht_r[3]);
              slot_r  <= 2'd0;
              cnt_r   <= '0;
              state_r <= S_MUL;
            end
          end
        end

        S_MUL: begin
          // Products come out in the cycle after issue; pair them up as a*b - c*d
          if (cnt_r != 5'd0) begin
            if (!jdx[0]) acc_r <= prod;
            else vec_r[jdx[3:1]] <= acc_r - prod;
          end
          if (cnt_r == 5'd14) begin
            if (vec_r[0] == '0) begin
              out_r       <= '{degenerate: 1'b1, default: '0};
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              flip_r  <= vec_r[0][ProdW-1];
              vsel_r  <= 1'b0;
              state_r <= S_LOAD;
            end
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end

        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [ProdW-1:0] v;
            logic [ProdW-1:0]        vn;
            v  = vsel_r ? vec_r[4+i] : vec_r[1+i];
            vn = -v;
            sgn_r[i] <= v[ProdW-1];
            w_r[i]   <= v[ProdW-1] ? vn[MagW-1:0] : v[MagW-1:0];
          end
          state_r <= S_ALIGN;
        end

        S_ALIGN: begin
          // Shift left until the largest magnitude fills the top bit; an all-zero vector is degenerate
          if (w_or == '0) begin
            out_r       <= '{degenerate: 1'b1, default: '0};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (w_or[MagW-1]) begin
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end else if (w_or[MagW-1 -: 16] == '0) begin
            for (int i = 0; i < 3; i++) w_r[i] <= w_r[i] << 16;
          end else begin
            for (int i = 0; i < 3; i++) w_r[i] <= w_r[i] << 1;
          end
        end

        S_SQ: begin
          if (cnt_r == 5'd3) begin
            x_r     <= sum_r + prod[SqW-1:0];
            root_r  <= '0;
            sbit_r  <= CsW'(1) << (SqW - 2 + (SqW % 2));
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            if (cnt_r != 5'd0) sum_r <= sum_r + prod[SqW-1:0];
            cnt_r <= cnt_r + 5'd1;
          end
        end

        S_SQRT: begin
          // One step per bit pair, from 2^60 down to 2^0
          if (cs_ge) begin
            x_r    <= cs_diff[SqW-1:0];
            root_r <= (root_r >> 1) + sbit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          if (cnt_r == 5'd30) begin
            ci_r    <= '0;
            state_r <= S_DSET;
          end
          cnt_r <= cnt_r + 5'd1;
        end

        S_DSET: begin
          // Quotient fits in 16 bits, so start with the upper part as remainder
          rem_r   <= (NormW+1)'(num[NumW-1:16]);
          nlo_r   <= num[15:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r <= cs_ge ? cs_diff[NormW:0] : {rem_r[NormW-1:0], nlo_r[15]};
          nlo_r <= nlo_r << 1;
          q_r   <= q_fin;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            if (vsel_r) bn_r[ci_r] <= q_signed;
            else tn_r[ci_r] <= q_signed;
            if (ci_r != 2'd2) begin
              ci_r    <= ci_r + 2'd1;
              state_r <= S_DSET;
            end else if (!vsel_r) begin
              vsel_r  <= 1'b1;
              state_r <= S_LOAD;
            end else begin
              out_r.tangent_x   <= tn_r[0];
              out_r.tangent_y   <= tn_r[1];
              out_r.tangent_z   <= tn_r[2];
              out_r.bitangent_x <= bn_r[0];
              out_r.bitangent_y <= bn_r[1];
              out_r.bitangent_z <= q_signed;
              out_r.degenerate  <= 1'b0;
              out_valid_r       <= 1'b1;
              state_r           <= S_IDLE;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ttb_chk.sv @@
`default_nettype none
module ttb_chk import ttb_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire ttb_out_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Degenerate results carry zero vectors
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.tangent_x == 0 && out_data.tangent_y == 0 && out_data.tangent_z == 0 &&
      out_data.bitangent_x == 0 && out_data.bitangent_y == 0 && out_data.bitangent_z == 0)
    else $error("degenerate result with nonzero vector");

  // The x components of tangent and bitangent stay within one in Q1.14
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      $signed(out_data.tangent_x) >= -16384 && $signed(out_data.tangent_x) <= 16384 &&
      $signed(out_data.bitangent_x) >= -16384 && $signed(out_data.bitangent_x) <= 16384)
    else $error("component out of unit range");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_tangent_basis_unit ttb_chk u_ttb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ test/triangle_tangent_basis_unit_tb.sv @@
`default_nettype none
module triangle_tangent_basis_unit_tb;
  import ttb_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Tangent-basis predictor and store of expected basis results.
  class basis_scoreboard;
    longint held_pos[6];
    longint held_uv[4];
    int unsigned slot;
    ttb_out_t pending_basis[$];
    int unsigned error_count;
    int unsigned basis_seen;
    int unsigned degenerate_seen;
    int unsigned vertices_seen;

    function new();
      foreach (held_pos[i]) held_pos[i] = 0;
      foreach (held_uv[i]) held_uv[i] = 0;
      slot = 0;
      error_count = 0;
      basis_seen = 0;
      degenerate_seen = 0;
      vertices_seen = 0;
    endfunction

    function wide_t mul_exact(longint a, longint b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Normalize to Q1.14; returns 0 when the vector is all zero.
    function bit normalize(input wide_t v[3], input bit flip,
                           output logic [CompW-1:0] dst[3]);
      logic [127:0] m[3];
      longint unsigned c[3], s, n, q;
      int len, l;
      bit neg;
      len = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (v[i] < 0) ? -v[i] : v[i];
        l = 0;
        for (int k = 127; k >= 0; k--)
          if (l == 0 && m[i][k]) l = k + 1;
        if (l > len) len = l;
      end
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        if (len > NormW) c[i] = 64'(m[i] >> (len - NormW));
        else c[i] = 64'(m[i] << (NormW - len));
        c[i] = c[i] & 64'h3FFF_FFFF;
        s = s + c[i] * c[i];
      end
      n = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = (c[i] * 16384 + n / 2) / n;
        neg = (v[i] < 0) != flip;
        dst[i] = neg ? CompW'(-q) : CompW'(q);
      end
      return 1;
    endfunction

    function void note_vertex(ttb_in_t vx);
      longint p[3], e1[3], e2[3], du1, dv1, du2, dv2;
      wide_t det, tv[3], bv[3];
      logic [CompW-1:0] tq[3], bq[3];
      ttb_out_t exp_basis;
      bit ok;
      int unsigned k;
      vertices_seen++;
      p[0] = vx.pos_x;
      p[1] = vx.pos_y;
      p[2] = vx.pos_z;
      if (slot != 2) begin
        k = (slot == 1) ? 1 : 0;
        for (int i = 0; i < 3; i++) held_pos[k*3+i] = p[i];
        held_uv[k*2] = vx.tex_u;
        held_uv[k*2+1] = vx.tex_v;
        slot = k + 1;
        return;
      end
      slot = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = held_pos[3+i] - held_pos[i];
        e2[i] = p[i] - held_pos[3+i];
      end
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = longint'(vx.tex_u) - held_uv[2];
      dv2 = longint'(vx.tex_v) - held_uv[3];
      det = mul_exact(du1, dv2) - mul_exact(du2, dv1);
      for (int i = 0; i < 3; i++) begin
        tv[i] = mul_exact(dv2, e1[i]) - mul_exact(dv1, e2[i]);
        bv[i] = mul_exact(du1, e2[i]) - mul_exact(du2, e1[i]);
      end
      ok = (det != 0);
      if (ok) ok = normalize(tv, det < 0, tq);
      if (ok) ok = normalize(bv, det < 0, bq);
      exp_basis = '0;
      if (ok) begin
        exp_basis.tangent_x = tq[0];
        exp_basis.tangent_y = tq[1];
        exp_basis.tangent_z = tq[2];
        exp_basis.bitangent_x = bq[0];
        exp_basis.bitangent_y = bq[1];
        exp_basis.bitangent_z = bq[2];
      end
      exp_basis.degenerate = !ok;
      pending_basis = {pending_basis, exp_basis};
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH basis %0d %s: got %0d expected %0d",
               basis_seen, what, got, want);
      error_count++;
    endtask

    task check_basis(ttb_out_t got);
      ttb_out_t want;
      if (pending_basis.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending_basis.pop_front();
      if (got.tangent_x !== want.tangent_x) report("tangent_x", got.tangent_x, want.tangent_x);
      if (got.tangent_y !== want.tangent_y) report("tangent_y", got.tangent_y, want.tangent_y);
      if (got.tangent_z !== want.tangent_z) report("tangent_z", got.tangent_z, want.tangent_z);
      if (got.bitangent_x !== want.bitangent_x)
        report("bitangent_x", got.bitangent_x, want.bitangent_x);
      if (got.bitangent_y !== want.bitangent_y)
        report("bitangent_y", got.bitangent_y, want.bitangent_y);
      if (got.bitangent_z !== want.bitangent_z)
        report("bitangent_z", got.bitangent_z, want.bitangent_z);
      if (got.degenerate !== want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
      if (want.degenerate) degenerate_seen++;
      basis_seen++;
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  ttb_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  ttb_out_t out_data;

  basis_scoreboard sb = new();
  bit calm = 0;  // no idling on either side while set

  triangle_tangent_basis_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Sample both channels at the rising edge; a transaction counts only on valid and ready.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_vertex(in_data);
    if (rst_n && out_valid && out_ready) sb.check_basis(out_data);
  end

  // Result side: hold ready low for a drawn number of cycles, then high until one transaction.
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 14);
      out_ready = 0;
      repeat (n) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Present one vertex after a drawn gap; hold it until the transaction completes.
  task send_vertex(ttb_in_t vx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
    in_data = vx;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  task send_triangle(ttb_in_t a, ttb_in_t b, ttb_in_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  function logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function ttb_in_t make_vertex(int pos_mode, int uv_mode);
    ttb_in_t vx;
    vx.pos_x = pick_coord(pos_mode);
    vx.pos_y = pick_coord(pos_mode);
    vx.pos_z = pick_coord(pos_mode);
    vx.tex_u = pick_coord(uv_mode);
    vx.tex_v = pick_coord(uv_mode);
    return vx;
  endfunction

  function ttb_in_t fill(logic [31:0] p, logic [31:0] u, logic [31:0] v);
    ttb_in_t vx;
    vx.pos_x = p;
    vx.pos_y = p;
    vx.pos_z = p;
    vx.tex_u = u;
    vx.tex_v = v;
    return vx;
  endfunction

  initial begin : stimulus
    ttb_in_t a, b, c;
    int mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: all-zero triangle, so a zero determinant.
    send_triangle('0, '0, '0);
    // Extremes of every field, positive and negative determinant.
    send_triangle(fill(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                  fill(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000),
                  fill(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_triangle(fill(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000),
                  fill(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF),
                  fill(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    // Nonzero determinant but coincident positions: tangent and bitangent both zero.
    send_triangle(fill(32'h1234_5678, 0, 0), fill(32'h1234_5678, 32'h1_0000, 0),
                  fill(32'h1234_5678, 32'h1_0000, 32'h1_0000));
    // Collinear texture coordinates: zero determinant with real geometry.
    a = make_vertex(1, 2); b = a; c = a;
    b.pos_x = a.pos_x + 32'h1_0000; c.pos_y = a.pos_y + 32'h1_0000;
    b.tex_u = 32'h1_0000; b.tex_v = 32'h1_0000; a.tex_u = 0; a.tex_v = 0;
    c.tex_u = 32'h2_0000; c.tex_v = 32'h2_0000;
    send_triangle(a, b, c);
    // Unit right triangle, mirrored UV for a negative determinant.
    send_triangle(fill(0, 0, 0), '{32'h1_0000, 0, 0, 32'h1_0000, 0},
                  '{32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 32'h1_0000});
    send_triangle(fill(0, 0, 0), '{32'h1_0000, 0, 0, 32'hFFFF_0000, 0},
                  '{32'h1_0000, 32'h1_0000, 0, 32'hFFFF_0000, 32'h1_0000});

    // Random: ordinary meshes most often, also huge, tiny and extreme coordinates.
    for (int t = 0; t < 545; t++) begin
      calm = (t >= 200 && t < 240);
      if (t == 120 || t == 400) begin
        // Drain the block completely before carrying on.
        while (sb.pending_basis.size() != 0) @(negedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        a = make_vertex(1, 1); b = make_vertex(1, 1); c = make_vertex(1, 1);
      end else if (mode < 6) begin
        a = make_vertex(0, 0); b = make_vertex(0, 0); c = make_vertex(0, 0);
      end else if (mode < 8) begin
        a = make_vertex(2, 2); b = make_vertex(2, 2); c = make_vertex(2, 2);
      end else if (mode == 8) begin
        a = make_vertex(3, 3); b = make_vertex(3, 3); c = make_vertex(3, 3);
      end else begin
        // Shared vertex or repeated UV to hit the degenerate paths.
        a = make_vertex(1, 1); b = make_vertex(1, 1);
        c = $urandom_range(0, 1) ? a : b;
        c.pos_x = c.pos_x + 32'($urandom_range(0, 1));
      end
      send_triangle(a, b, c);
    end
    calm = 0;

    while (sb.pending_basis.size() != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d vertices and %0d tangent bases, %0d of them degenerate.",
             sb.vertices_seen, sb.basis_seen, sb.degenerate_seen);
    if (sb.error_count == 0 && sb.pending_basis.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Timeout with %0d results outstanding", sb.pending_basis.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
